/* src/ssfr_pkg.sv */
// Package for the servo status frame receiver.
// Holds the op, phase and outcome codes and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package ssfr_pkg;

  localparam logic [7:0] HEADER_BYTE     = 8'hFF;
  localparam logic [7:0] BROADCAST_ID    = 8'hFE;
  localparam logic [7:0] ACK_LENGTH      = 8'd2;
  localparam logic [7:0] SEARCH_LIMIT_RST = 8'd11;

  typedef enum logic [1:0] {
    OP_ARM     = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HUNT  = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_ERR   = 3'd4,
    PH_PARAM = 3'd5,
    PH_SUM   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    OUT_OK       = 3'd0,
    OUT_TIMEOUT  = 3'd1,
    OUT_NOHEADER = 3'd2,
    OUT_BADID    = 3'd3,
    OUT_BADLEN   = 3'd4,
    OUT_BADSUM   = 3'd5
  } outcome_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    outcome_t   outcome;
    logic [7:0] servo_error;
    logic [7:0] responder_id;
  } result_t;

endpackage

/* src/servo_status_frame_receiver.sv */
// Servo status frame receiver: top level, parser state and output buffer.
// Depends on ssfr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: an arm
//   (in_op 0, with in_expected_id, in_param_count, in_ack_mode), a received
//   line byte (in_op 1, in_rx_byte) or a reply timeout (in_op 2).
//   After an arm the block hunts for two 0xFF header bytes within
//   header_search_limit bytes, then takes id, length, error, the parameter
//   bytes and the checksum. Each parameter byte leaves as a data result
//   (out_is_status 0); every armed reply ends with one status result.
//   Config channel (cfg_valid/cfg_ready) writes header_search_limit; it is
//   always ready and should be written only while the block is idle.
//   A result enters the output register (or the skid entry while the output
//   is stalled) from the input transfer that causes it. Throughput: one item
//   per cycle while in_ready is high: one parser state update per transfer.
//   A two-entry output buffer (output register plus skid) lets one more
//   item in while a result waits; in_ready drops only while both are full.
//   Reset (rst_n low, synchronous) returns the parser to idle, empties the
//   buffer and sets header_search_limit to 11.
`timescale 1ns / 1ps

module servo_status_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_expected_id,
  input  logic [7:0] in_param_count,
  input  logic       in_ack_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_status,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_outcome,
  output logic [7:0] out_servo_error,
  output logic [7:0] out_responder_id,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_header_search_limit
);
  import ssfr_pkg::*;

  logic [7:0] limit_r;

  phase_t     phase_r, phase_nxt;
  logic       last_ff_r, last_ff_nxt;
  logic [7:0] search_cnt_r, search_cnt_nxt;
  logic [7:0] want_id_r, want_id_nxt;
  logic [7:0] want_params_r, want_params_nxt;
  logic       ack_r, ack_nxt;
  logic [7:0] params_left_r, params_left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] got_id_r, got_id_nxt;
  logic [7:0] got_len_r, got_len_nxt;
  logic [7:0] got_err_r, got_err_nxt;

  logic       res_valid;
  result_t    res;

  result_t    out_r, skid_r;
  logic       out_valid_r, skid_valid_r;

  logic       in_fire, push, pop;
  logic [7:0] cnt_inc, params_dec;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && res_valid;
  assign pop       = out_valid_r && out_ready;

  assign cnt_inc    = search_cnt_r + 8'd1;
  assign params_dec = params_left_r - 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    last_ff_nxt     = last_ff_r;
    search_cnt_nxt  = search_cnt_r;
    want_id_nxt     = want_id_r;
    want_params_nxt = want_params_r;
    ack_nxt         = ack_r;
    params_left_nxt = params_left_r;
    sum_nxt         = sum_r;
    got_id_nxt      = got_id_r;
    got_len_nxt     = got_len_r;
    got_err_nxt     = got_err_r;
    res_valid       = 1'b0;
    res.is_status    = 1'b1;
    res.data_byte    = 8'd0;
    res.outcome      = OUT_OK;
    res.servo_error  = 8'd0;
    res.responder_id = got_id_r;

    case (in_op)
      OP_ARM: begin
        want_id_nxt     = in_expected_id;
        want_params_nxt = in_param_count;
        ack_nxt         = in_ack_mode;
        phase_nxt       = PH_HUNT;
        last_ff_nxt     = 1'b0;
        search_cnt_nxt  = 8'd0;
        params_left_nxt = 8'd0;
        sum_nxt         = 8'd0;
        got_id_nxt      = 8'd0;
        got_len_nxt     = 8'd0;
        got_err_nxt     = 8'd0;
      end
      OP_TIMEOUT: begin
        if (phase_r != PH_IDLE) begin
          res_valid   = 1'b1;
          res.outcome = OUT_TIMEOUT;
          phase_nxt   = PH_IDLE;
        end
      end
      OP_BYTE: begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_HUNT: begin
            if (last_ff_r && in_rx_byte == HEADER_BYTE) begin
              phase_nxt = PH_ID;
            end else begin
              last_ff_nxt    = (in_rx_byte == HEADER_BYTE);
              search_cnt_nxt = cnt_inc;
              if (cnt_inc >= limit_r) begin
                res_valid   = 1'b1;
                res.outcome = OUT_NOHEADER;
                phase_nxt   = PH_IDLE;
              end
            end
          end
          PH_ID: begin
            got_id_nxt = in_rx_byte;
            sum_nxt    = in_rx_byte;
            phase_nxt  = PH_LEN;
          end
          PH_LEN: begin
            got_len_nxt = in_rx_byte;
            sum_nxt     = sum_r + in_rx_byte;
            phase_nxt   = PH_ERR;
          end
          PH_ERR: begin
            got_err_nxt     = in_rx_byte;
            sum_nxt         = sum_r + in_rx_byte;
            params_left_nxt = ack_r ? 8'd0 : want_params_r;
            phase_nxt       = (!ack_r && want_params_r != 8'd0) ? PH_PARAM : PH_SUM;
          end
          PH_PARAM: begin
            sum_nxt          = sum_r + in_rx_byte;
            params_left_nxt  = params_dec;
            if (params_dec == 8'd0) phase_nxt = PH_SUM;
            res_valid        = 1'b1;
            res.is_status    = 1'b0;
            res.data_byte    = in_rx_byte;
            res.responder_id = 8'd0;
          end
          PH_SUM: begin
            res_valid = 1'b1;
            phase_nxt = PH_IDLE;
            // ack checks first, in priority order, then the checksum
            if (ack_r && got_id_r != want_id_r && want_id_r != BROADCAST_ID) begin
              res.outcome = OUT_BADID;
            end else if (ack_r && got_len_r != ACK_LENGTH) begin
              res.outcome = OUT_BADLEN;
            end else if (~sum_r != in_rx_byte) begin
              res.outcome = OUT_BADSUM;
            end else begin
              res.outcome     = OUT_OK;
              res.servo_error = got_err_r;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= SEARCH_LIMIT_RST;
      phase_r       <= PH_IDLE;
      last_ff_r     <= 1'b0;
      search_cnt_r  <= 8'd0;
      want_id_r     <= 8'd0;
      want_params_r <= 8'd0;
      ack_r         <= 1'b0;
      params_left_r <= 8'd0;
      sum_r         <= 8'd0;
      got_id_r      <= 8'd0;
      got_len_r     <= 8'd0;
      got_err_r     <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_header_search_limit;
      if (in_fire) begin
        phase_r       <= phase_nxt;
        last_ff_r     <= last_ff_nxt;
        search_cnt_r  <= search_cnt_nxt;
        want_id_r     <= want_id_nxt;
        want_params_r <= want_params_nxt;
        ack_r         <= ack_nxt;
        params_left_r <= params_left_nxt;
        sum_r         <= sum_nxt;
        got_id_r      <= got_id_nxt;
        got_len_r     <= got_len_nxt;
        got_err_r     <= got_err_nxt;
      end
    end
  end

  // output register plus skid; skid only fills while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (push)    out_r <= res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_status    = out_r.is_status;
  assign out_data_byte    = out_r.data_byte;
  assign out_outcome      = out_r.outcome;
  assign out_servo_error  = out_r.servo_error;
  assign out_responder_id = out_r.responder_id;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled while output was free");

  a_status_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.is_status |=> phase_r == PH_IDLE)
    else $error("parser not idle after a status transfer");

  a_param_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PARAM |-> params_left_r != 8'd0)
    else $error("parameter phase with no bytes left");
`endif

endmodule
